// File: design/zerd_pkg.sv
// Package with the shared types, constants and codes of the zone entry release detector.
package zerd_pkg;

  localparam int CoordBits        = 12;
  localparam int CentreBits       = CoordBits + 1;
  localparam int CountBits        = 14;
  localparam int StreakCapDefault = 10000;
  localparam int CfgIndexBits     = 3;
  localparam int CfgDataBits      = 14;

  typedef enum logic [3:0] {
    ReasonNoHold   = 4'd0,
    ReasonInactive = 4'd1,
    ReasonFired    = 4'd2,
    ReasonUnlocked = 4'd3,
    ReasonNoObject = 4'd4,
    ReasonNoZone   = 4'd5,
    ReasonEntered  = 4'd6,
    ReasonDwell    = 4'd7,
    ReasonInside   = 4'd8,
    ReasonOutside  = 4'd9,
    ReasonCleared  = 4'd10
  } reason_e;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgZoneLeft    = 3'd0,
    CfgZoneTop     = 3'd1,
    CfgZoneRight   = 3'd2,
    CfgZoneBottom  = 3'd3,
    CfgZonePresent = 3'd4,
    CfgDwellFrames = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic                 command;
    logic [CoordBits-1:0] box_left;
    logic [CoordBits-1:0] box_top;
    logic [CoordBits-1:0] box_right;
    logic [CoordBits-1:0] box_bottom;
    logic                 box_present;
    logic                 hold_active;
    logic                 action_active;
    logic                 type_locked;
    logic                 fired_in_hold;
  } in_word_t;

  typedef struct packed {
    logic                  fire_now;
    logic                  entered_now;
    logic                  inside_zone;
    logic                  owner_flag;
    reason_e               reason_code;
    logic [CentreBits-1:0] centre_x2;
    logic [CentreBits-1:0] centre_y2;
  } out_word_t;

  typedef struct packed {
    logic [CoordBits-1:0] zone_left;
    logic [CoordBits-1:0] zone_top;
    logic [CoordBits-1:0] zone_right;
    logic [CoordBits-1:0] zone_bottom;
    logic                 zone_present;
    logic [CountBits-1:0] dwell_frames;
  } cfg_t;

  typedef struct packed {
    logic                 was_inside;
    logic                 has_released;
    logic                 owner_latch;
    logic [CountBits-1:0] inside_count;
  } state_t;

endpackage

// File: design/zerd_eval.sv
// Combinational evaluation of one word: gate chain, zone test, streak and release decision.
module zerd_eval #(
  parameter int StreakCap = zerd_pkg::StreakCapDefault
) (
  input  zerd_pkg::in_word_t  word_i,
  input  zerd_pkg::cfg_t      cfg_i,
  input  zerd_pkg::state_t    state_i,
  output zerd_pkg::out_word_t result_o,
  output zerd_pkg::state_t    state_o
);

  localparam logic [zerd_pkg::CountBits-1:0] CapVal = zerd_pkg::CountBits'(StreakCap);

  logic [zerd_pkg::CentreBits-1:0] cx2, cy2;
  logic [zerd_pkg::CentreBits-1:0] zl2, zt2, zr2, zb2;
  logic                            in_zone, entered, dwell;
  logic [zerd_pkg::CountBits-1:0]  count_next, dwell_need;

  // Doubled centre: the sum of two box coordinates never overflows the extra bit.
  assign cx2 = zerd_pkg::CentreBits'(word_i.box_left) + zerd_pkg::CentreBits'(word_i.box_right);
  assign cy2 = zerd_pkg::CentreBits'(word_i.box_top) + zerd_pkg::CentreBits'(word_i.box_bottom);
  assign zl2 = {cfg_i.zone_left, 1'b0};
  assign zt2 = {cfg_i.zone_top, 1'b0};
  assign zr2 = {cfg_i.zone_right, 1'b0};
  assign zb2 = {cfg_i.zone_bottom, 1'b0};

  assign in_zone = (cx2 >= zl2) && (cx2 <= zr2) && (cy2 >= zt2) && (cy2 <= zb2);
  assign entered = in_zone && !state_i.was_inside;

  always_comb begin
    if (!in_zone) begin
      count_next = '0;
    end else if (state_i.inside_count < CapVal) begin
      count_next = state_i.inside_count + 1'b1;
    end else begin
      count_next = state_i.inside_count;
    end
  end

  // A dwell setting of zero behaves as one.
  assign dwell_need = (cfg_i.dwell_frames == '0) ? zerd_pkg::CountBits'(1)
                                                 : cfg_i.dwell_frames;
  assign dwell      = !state_i.has_released && (count_next >= dwell_need);

  always_comb begin
    result_o             = '0;
    result_o.owner_flag  = state_i.owner_latch;
    state_o              = state_i;
    if (word_i.command) begin
      state_o              = '0;
      result_o.owner_flag  = 1'b0;
      result_o.reason_code = zerd_pkg::ReasonCleared;
    end else if (!word_i.hold_active) begin
      state_o.was_inside   = 1'b0;
      result_o.reason_code = zerd_pkg::ReasonNoHold;
    end else if (!word_i.action_active) begin
      state_o.was_inside   = 1'b0;
      state_o.inside_count = '0;
      result_o.reason_code = zerd_pkg::ReasonInactive;
    end else if (word_i.fired_in_hold) begin
      result_o.reason_code = zerd_pkg::ReasonFired;
    end else if (!word_i.type_locked) begin
      result_o.reason_code = zerd_pkg::ReasonUnlocked;
    end else if (!word_i.box_present) begin
      state_o.was_inside   = 1'b0;
      result_o.reason_code = zerd_pkg::ReasonNoObject;
    end else if (!cfg_i.zone_present) begin
      state_o.was_inside   = 1'b0;
      result_o.reason_code = zerd_pkg::ReasonNoZone;
    end else begin
      state_o.inside_count = count_next;
      state_o.was_inside   = in_zone;
      if (entered) begin
        state_o.owner_latch = 1'b1;
      end
      result_o.owner_flag  = state_i.owner_latch | entered;
      result_o.inside_zone = in_zone;
      result_o.entered_now = entered;
      result_o.centre_x2   = cx2;
      result_o.centre_y2   = cy2;
      if ((entered || dwell) && !state_i.has_released) begin
        result_o.fire_now    = 1'b1;
        result_o.reason_code = entered ? zerd_pkg::ReasonEntered : zerd_pkg::ReasonDwell;
        state_o.has_released = 1'b1;
      end else if (in_zone) begin
        result_o.reason_code = zerd_pkg::ReasonInside;
      end else begin
        result_o.reason_code = zerd_pkg::ReasonOutside;
      end
    end
  end

endmodule

// File: design/zone_entry_release_detector.sv
// Top level of the zone entry release detector: input register, evaluation, result register.
//
// An accepted word goes from the input register through the evaluation into the result
// register. Throughput: one word per cycle while the output is not stalled; the tracking
// state is updated at the same edge that loads the result register, so the next word
// sees it at once. Reset: clears the tracking state and both valid flags, and loads the
// zone registers with their defaults (full frame, no zone defined, dwell of three frames).
module zone_entry_release_detector #(
  parameter int StreakCap = zerd_pkg::StreakCapDefault
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  zerd_pkg::in_word_t                   in_word_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output zerd_pkg::out_word_t                  out_word_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [zerd_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [zerd_pkg::CfgDataBits-1:0]     cfg_data_i
);

  // Configuration registers. Writes are always taken; an unknown index is dropped.
  zerd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        zerd_pkg::CfgZoneLeft:    cfg_d.zone_left    = cfg_data_i[zerd_pkg::CoordBits-1:0];
        zerd_pkg::CfgZoneTop:     cfg_d.zone_top     = cfg_data_i[zerd_pkg::CoordBits-1:0];
        zerd_pkg::CfgZoneRight:   cfg_d.zone_right   = cfg_data_i[zerd_pkg::CoordBits-1:0];
        zerd_pkg::CfgZoneBottom:  cfg_d.zone_bottom  = cfg_data_i[zerd_pkg::CoordBits-1:0];
        zerd_pkg::CfgZonePresent: cfg_d.zone_present = cfg_data_i[0];
        zerd_pkg::CfgDwellFrames: cfg_d.dwell_frames = cfg_data_i[zerd_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zone_left    <= '0;
      cfg_q.zone_top     <= '0;
      cfg_q.zone_right   <= '1;
      cfg_q.zone_bottom  <= '1;
      cfg_q.zone_present <= 1'b0;
      cfg_q.dwell_frames <= zerd_pkg::CountBits'(3);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Input register. It moves on whenever the result register can take its word,
  // so a result waiting on the output side still lets one more word in.
  logic               s1_valid_q;
  zerd_pkg::in_word_t s1_word_q;
  logic               out_valid_q;
  zerd_pkg::out_word_t out_word_q;
  logic               s1_go;

  assign s1_go      = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_word_q <= in_word_i;
    end
  end

  // Evaluation of the registered word against the tracking state.
  zerd_pkg::state_t    state_q, state_d;
  zerd_pkg::out_word_t result;

  zerd_eval #(
    .StreakCap(StreakCap)
  ) u_eval (
    .word_i  (s1_word_q),
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .result_o(result),
    .state_o (state_d)
  );

  // The state only advances together with a result entering the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_valid_q) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // While a result is shown, the state is exactly what its word left behind.
  a_release_latched : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.fire_now |-> state_q.has_released)
    else $error("release shown without the release latch set");

  a_release_reason : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.fire_now |->
      (out_word_o.reason_code == zerd_pkg::ReasonEntered ||
       out_word_o.reason_code == zerd_pkg::ReasonDwell))
    else $error("release with a reason other than entry or dwell");

  a_streak_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.inside_count <= zerd_pkg::CountBits'(StreakCap))
    else $error("inside streak above its cap");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.reason_code == zerd_pkg::ReasonCleared |->
      (state_q == '0))
    else $error("clear word left tracking state behind");

  a_entry_owns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.entered_now |-> out_word_o.owner_flag && state_q.owner_latch)
    else $error("entry without ownership");

endmodule
